// ===== rtl/assert_macros.svh =====
// Assertion helpers for the Sv39 walk tracer.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define S39W_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication.
`define S39W_IMPLIES(label, ante, cons, msg) \
  `S39W_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/s39w_pkg.sv =====
// Shared types and constants for the Sv39 page-walk tracer.
// No dependencies; used by s39w_store and sv39_page_walk_trace.
package s39w_pkg;

  localparam int TABLE_PAGES = 64;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int SLOT_W      = 9;
  localparam int STORE_DEPTH = TABLE_PAGES * (1 << SLOT_W);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int POOL_LOG2   = 6;
  localparam int POOL_CELLS  = 1 << POOL_LOG2;
  localparam int Q_W         = POOL_LOG2 + 1;
  localparam int PPN_W       = 44;
  localparam int REM_W       = PPN_W + POOL_LOG2;
  localparam int PA_W        = 56;

  localparam logic signed [6:0] CELL_NONE = -7'sd1;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LIMIT  = 2'd1;
  localparam logic [1:0] ERR_WINDOW = 2'd2;

  localparam logic MODE_WRITE = 1'b0;

  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  localparam logic [1:0] REG_ROOT_PAGE  = 2'd0;
  localparam logic [1:0] REG_USER_LIMIT = 2'd1;
  localparam logic [1:0] REG_POOL_START = 2'd2;
  localparam logic [1:0] REG_POOL_END   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_OUT,
    ST_POOL_SPAN,
    ST_POOL_LO,
    ST_POOL_HI,
    ST_DIV
  } s39w_state_t;

  // Packs MSB first, so it lines up with out_tdata bit for bit.
  typedef struct packed {
    logic [1:0]        request_error;
    logic signed [6:0] pool_cell;
    logic              leaf_found;
    logic [PA_W-1:0]   phys_addr;
    logic              level_present;
    logic [9:0]        flag_bits;
    logic [63:0]       pte_word;
    logic [8:0]        table_index;
    logic [1:0]        walk_level;
  } s39w_rec_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } s39w_mem_req_t;

endpackage

// ===== rtl/sv39_page_walk_trace.sv =====
// Sv39 page-walk tracer: a write item (mode 0) stores one PTE word. A query
// first gets the limit check on acceptance, then per level a store read, a
// decode and an output transfer; a leaf adds a pool range check and, when it
// lies in the pool, a restoring division for the pool cell, all on a single
// shared 56-bit subtractor. The block takes one item at a time and holds
// in_tready low until the last record of a query has gone out.
// The PTE store holds no reset value; reading a slot never written is
// undefined.
`include "assert_macros.svh"

module sv39_page_walk_trace (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [38:0] virt_addr, [44:39] table_page, [53:45] slot, [117:54] pte_value
  input  logic [119:0]  in_tdata,
  // [0] mode
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [1:0] walk_level, [10:2] table_index, [74:11] pte_word, [84:75] flag_bits,
  // [85] level_present, [141:86] phys_addr, [142] leaf_found,
  // [149:143] pool_cell, [151:150] request_error
  output logic [151:0]  out_tdata,
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [55:0]   cfg_wdata
);
  import s39w_pkg::*;

  s39w_state_t       state_r, state_nxt;
  logic [1:0]        level_r, level_nxt;
  logic [PPN_W-1:0]  page_r, page_nxt;
  logic [26:0]       vpn_r, vpn_nxt;
  s39w_rec_t         out_rec_r, out_rec_nxt;
  logic              last_r, last_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [PPN_W-1:0]  div_d_r, div_d_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [2:0]        cnt_r, cnt_nxt;

  logic [5:0]        root_page_r;
  logic [39:0]       user_limit_r;
  logic [PA_W-1:0]   pool_start_r;
  logic [PA_W-1:0]   pool_end_r;

  // Shared subtract/compare unit.
  logic [PA_W-1:0]   sub_a, sub_b;
  logic [PA_W:0]     sub_diff;
  logic              sub_ge;

  s39w_mem_req_t     mem_req;
  logic [63:0]       rd_data;
  logic [8:0]        idx;
  logic [Q_W-1:0]    q_fin;

  logic [38:0]       in_va;
  logic [5:0]        in_tp;
  logic [8:0]        in_slot;
  logic [63:0]       in_pte;

  assign in_va   = in_tdata[38:0];
  assign in_tp   = in_tdata[44:39];
  assign in_slot = in_tdata[53:45];
  assign in_pte  = in_tdata[117:54];

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[PA_W];

  s39w_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    case (level_r)
      LVL_ROOT: idx = vpn_r[26:18];
      LVL_MID:  idx = vpn_r[17:9];
      default:  idx = vpn_r[8:0];
    endcase
  end

  assign q_fin = {q_r[Q_W-2:0], sub_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_page_r  <= '0;
      user_limit_r <= 40'h40_0000_0000;
      pool_start_r <= 56'h8000_0000;
      pool_end_r   <= 56'h8800_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROOT_PAGE:  root_page_r  <= cfg_wdata[5:0];
        REG_USER_LIMIT: user_limit_r <= cfg_wdata[39:0];
        REG_POOL_START: pool_start_r <= cfg_wdata;
        REG_POOL_END:   pool_end_r   <= cfg_wdata;
        default:        root_page_r  <= root_page_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r   <= level_nxt;
    page_r    <= page_nxt;
    vpn_r     <= vpn_nxt;
    out_rec_r <= out_rec_nxt;
    last_r    <= last_nxt;
    rem_r     <= rem_nxt;
    div_d_r   <= div_d_nxt;
    q_r       <= q_nxt;
    cnt_r     <= cnt_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    level_nxt   = level_r;
    page_nxt    = page_r;
    vpn_nxt     = vpn_r;
    out_rec_nxt = out_rec_r;
    last_nxt    = last_r;
    rem_nxt     = rem_r;
    div_d_nxt   = div_d_r;
    q_nxt       = q_r;
    cnt_nxt     = cnt_r;
    in_tready   = 1'b0;
    mem_req     = '0;
    sub_a       = '0;
    sub_b       = '0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        sub_a     = PA_W'(in_va);
        sub_b     = PA_W'(user_limit_r);
        if (in_tvalid) begin
          if (in_tuser == MODE_WRITE) begin
            mem_req.we    = (32'(in_tp) < TABLE_PAGES);
            mem_req.addr  = {in_tp[PAGE_W-1:0], in_slot};
            mem_req.wdata = in_pte;
          end else begin
            vpn_nxt = in_va[38:12];
            if (sub_ge) begin
              out_rec_nxt               = '0;
              out_rec_nxt.request_error = ERR_LIMIT;
              out_rec_nxt.pool_cell     = CELL_NONE;
              last_nxt                  = 1'b1;
              state_nxt                 = ST_OUT;
            end else begin
              level_nxt = LVL_ROOT;
              page_nxt  = PPN_W'(root_page_r);
              state_nxt = ST_READ;
            end
          end
        end
      end

      ST_READ: begin
        if (page_r >= PPN_W'(TABLE_PAGES)) begin
          out_rec_nxt               = '0;
          out_rec_nxt.walk_level    = level_r;
          out_rec_nxt.table_index   = idx;
          out_rec_nxt.request_error = ERR_WINDOW;
          out_rec_nxt.pool_cell     = CELL_NONE;
          last_nxt                  = 1'b1;
          state_nxt                 = ST_OUT;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = {page_r[PAGE_W-1:0], idx};
          state_nxt    = ST_EVAL;
        end
      end

      ST_EVAL: begin
        out_rec_nxt.walk_level    = level_r;
        out_rec_nxt.table_index   = idx;
        out_rec_nxt.pte_word      = rd_data;
        out_rec_nxt.flag_bits     = rd_data[9:0];
        out_rec_nxt.level_present = rd_data[0];
        out_rec_nxt.phys_addr     = rd_data[0] ? {rd_data[53:10], 12'h000} : '0;
        out_rec_nxt.leaf_found    = 1'b0;
        out_rec_nxt.pool_cell     = CELL_NONE;
        out_rec_nxt.request_error = ERR_NONE;
        last_nxt                  = 1'b1;
        state_nxt                 = ST_OUT;
        if (rd_data[0]) begin
          if (rd_data[3:1] != 3'b000) begin
            out_rec_nxt.leaf_found = 1'b1;
            state_nxt              = ST_POOL_SPAN;
          end else if (level_r != LVL_LEAF) begin
            // pointer to the next table level
            last_nxt  = 1'b0;
            page_nxt  = rd_data[53:10];
            level_nxt = level_r - 2'd1;
          end
        end
      end

      ST_POOL_SPAN: begin
        sub_a     = pool_end_r;
        sub_b     = pool_start_r;
        div_d_nxt = sub_diff[PA_W-1:12];
        if (!sub_ge || sub_diff[PA_W-1:12] == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_POOL_LO;
        end
      end

      ST_POOL_LO: begin
        sub_a   = out_rec_r.phys_addr;
        sub_b   = pool_start_r;
        rem_nxt = {sub_diff[PA_W-1:12], {POOL_LOG2{1'b0}}};
        if (!sub_ge) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_POOL_HI;
        end
      end

      ST_POOL_HI: begin
        sub_a   = out_rec_r.phys_addr;
        sub_b   = pool_end_r;
        cnt_nxt = 3'(Q_W - 1);
        q_nxt   = '0;
        if (sub_ge) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // restoring division, one quotient bit per cycle, MSB first
        sub_a = PA_W'(rem_r);
        sub_b = PA_W'(div_d_r) << cnt_r;
        if (sub_ge) begin
          rem_nxt = sub_diff[REM_W-1:0];
        end
        q_nxt   = q_fin;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          if (q_fin >= Q_W'(POOL_CELLS)) begin
            out_rec_nxt.pool_cell = $signed(7'(POOL_CELLS - 1));
          end else begin
            out_rec_nxt.pool_cell = $signed(7'(q_fin));
          end
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_tready) begin
          state_nxt = last_r ? ST_IDLE : ST_READ;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_rec_r;
  assign out_tlast  = last_r;

  `S39W_IMPLIES(a_one_item, out_tvalid, !in_tready,
                "input accepted while a record is pending")
  `S39W_IMPLIES(a_mid_record, out_tvalid && !out_tlast,
                out_rec_r.level_present && out_rec_r.request_error == ERR_NONE &&
                out_rec_r.pool_cell == CELL_NONE,
                "non-final record not a clean table pointer")
  `S39W_IMPLIES(a_leaf_ends, out_tvalid && out_rec_r.leaf_found,
                out_tlast && out_rec_r.level_present,
                "leaf record not final or not valid")
  `S39W_ASSERT(a_walk_resumes,
               (state_r == ST_OUT && out_tready && !last_r) |=> state_r == ST_READ,
               "walk did not resume after a non-final transfer")

endmodule

// ===== rtl/s39w_store.sv =====
// PTE store: one 64-bit word per slot, single port, registered read.
// Depends on s39w_pkg.
module s39w_store (
  input  logic                    clk,
  input  s39w_pkg::s39w_mem_req_t req,
  output logic [63:0]             rd_data
);
  import s39w_pkg::*;

  logic [63:0] mem [STORE_DEPTH];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
